### design/aff_pkg.sv
// shared types and register codes for the affine cipher decrypt core
// no dependencies; used by the core and its checker
package aff_pkg;

  typedef enum logic [1:0] {
    CFG_MODULUS  = 2'd0,
    CFG_KEY_MULT = 2'd1,
    CFG_KEY_ADD  = 2'd2,
    CFG_SPARE    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_MOD,
    ST_DIV_WAIT,
    ST_E_INIT,
    ST_E_DIV,
    ST_E_MUL,
    ST_E_UPD,
    ST_INV_FIX,
    ST_B_SET,
    ST_CHECK,
    ST_DIFF,
    ST_PRODUCT,
    ST_P_MOD,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

### design/aff_div_cell.sv
// one restoring division step: shifts in a dividend bit, subtracts divisor
// when it fits; registered hand-off to the next cell; uses nothing else
module aff_div_cell #(
  parameter int W = 16,
  parameter int N = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  input  logic [W-1:0] in_rem,
  input  logic [N-1:0] in_num,
  input  logic [W-1:0] in_den,
  output logic         out_vld,
  output logic [W-1:0] out_rem,
  output logic [N-1:0] out_num,
  output logic [W-1:0] out_den
);

  logic         vld_r;
  logic [W-1:0] rem_r, rem_nxt;
  logic [N-1:0] num_r, num_nxt;
  logic [W-1:0] den_r;
  logic [W:0]   trial;
  logic         fits;

  always_comb begin
    trial   = {in_rem, in_num[N-1]};
    fits    = trial >= {1'b0, in_den};
    rem_nxt = fits ? W'(trial - {1'b0, in_den}) : trial[W-1:0];
    // quotient bits fill the low end as dividend bits leave the top
    num_nxt = {in_num[N-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= in_den;
  end

  assign out_vld = vld_r;
  assign out_rem = rem_r;
  assign out_num = num_r;
  assign out_den = den_r;

endmodule

### design/aff_div_chain.sv
// row of 2*W registered division cells; quotient and remainder come out of the last cell
// together with done; depends on aff_div_cell
module aff_div_chain #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2*W-1:0] dividend,
  input  logic [W-1:0]   divisor,
  output logic           done,
  output logic [2*W-1:0] quotient,
  output logic [W-1:0]   remainder
);

  localparam int N = 2 * W;

  logic         vld [0:N];
  logic [W-1:0] rem [0:N];
  logic [N-1:0] num [0:N];
  logic [W-1:0] den [0:N];

  assign vld[0] = start;
  assign rem[0] = '0;
  assign num[0] = dividend;
  assign den[0] = divisor;

  for (genvar k = 0; k < N; k++) begin : g_cell
    aff_div_cell #(.W(W), .N(N)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld[k]),
      .in_rem  (rem[k]),
      .in_num  (num[k]),
      .in_den  (den[k]),
      .out_vld (vld[k+1]),
      .out_rem (rem[k+1]),
      .out_num (num[k+1]),
      .out_den (den[k+1])
    );
  end

  assign done      = vld[N];
  assign quotient  = num[N];
  assign remainder = rem[N];

endmodule

### design/affine_cipher_decrypt_core.sv
// affine decrypt: plain = ((c - b) * a^-1) mod m, ambiguous when m == 0 or gcd(a, m) != 1
// with a cached inverse a word makes two passes through the 2*SYMBOL_BITS-cell divider
// (c mod m, then the product mod m), none when ambiguous; one word in flight, next taken
// once the result is loaded for output; first word after a config write adds the inverse
// search: one a mod m pass, one divider pass per euclid step, plus one b mod m pass
// rst_n synchronous active low: registers reload m=26 a=1 b=0, inverse cache cleared
module affine_cipher_decrypt_core #(
  parameter int SYMBOL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [SYMBOL_BITS-1:0] cipher_symbol
  input  logic [((SYMBOL_BITS+7)/8)*8-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [SYMBOL_BITS-1:0] plain_symbol
  output logic [((SYMBOL_BITS+7)/8)*8-1:0]  out_tdata,
  // [0] ambiguous
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  aff_pkg::cfg_idx_t                 cfg_index,
  input  logic [SYMBOL_BITS-1:0]            cfg_data
);
  import aff_pkg::*;

  localparam int W  = SYMBOL_BITS;
  localparam int TW = ((SYMBOL_BITS + 7) / 8) * 8;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [W-1:0] mod_r, kmul_r, kadd_r;
  logic         inv_ok_r, amb_r;
  logic [W-1:0] inv_r, bm_r, c_r;
  logic [W-1:0] or_r, r_r;
  logic signed [W+1:0] os_r, s_r, qs_r;
  logic [W-1:0] dq_r, drem_r;
  logic [W:0]   diff_r;
  logic [2*W-1:0] prod_r;
  logic [W-1:0] plain_r;
  logic         res_amb_r;
  logic         out_vld_r;
  logic [W-1:0] out_plain_r;
  logic         out_amb_r;

  logic           div_start;
  logic [2*W-1:0] div_dvd;
  logic [W-1:0]   div_den;
  logic           div_done;
  logic [2*W-1:0] div_quo;
  logic [W-1:0]   div_rem;

  logic signed [2*W+2:0] qs_full;
  logic signed [W+1:0]   mod_s;
  logic [W:0]            sum;

  aff_div_chain #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  wire in_acc  = in_tvalid && in_tready;
  wire out_free = !out_vld_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (inv_ok_r || mod_r == '0) ? ST_CHECK : ST_A_MOD;
        end
      end
      ST_A_MOD: begin
        state_nxt = ST_DIV_WAIT;
        ret_nxt   = ST_E_INIT;
      end
      ST_DIV_WAIT: if (div_done) state_nxt = ret_r;
      ST_E_INIT:   state_nxt = ST_E_DIV;
      ST_E_DIV: begin
        if (r_r == '0) begin
          state_nxt = ST_INV_FIX;
        end else begin
          state_nxt = ST_DIV_WAIT;
          ret_nxt   = ST_E_MUL;
        end
      end
      ST_E_MUL:   state_nxt = ST_E_UPD;
      ST_E_UPD:   state_nxt = ST_E_DIV;
      ST_INV_FIX: begin
        state_nxt = ST_DIV_WAIT;
        ret_nxt   = ST_B_SET;
      end
      ST_B_SET:   state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (amb_r || mod_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV_WAIT;
          ret_nxt   = ST_DIFF;
        end
      end
      ST_DIFF:    state_nxt = ST_PRODUCT;
      ST_PRODUCT: state_nxt = ST_P_MOD;
      ST_P_MOD: begin
        state_nxt = ST_DIV_WAIT;
        ret_nxt   = ST_FIN;
      end
      ST_FIN:     state_nxt = ST_DONE;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // divider requests and handshake outputs
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_den   = mod_r;
    in_tready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_A_MOD: begin
        div_start = 1'b1;
        div_dvd   = {{W{1'b0}}, kmul_r};
      end
      ST_E_DIV: begin
        div_start = (r_r != '0);
        div_dvd   = {{W{1'b0}}, or_r};
        div_den   = r_r;
      end
      ST_INV_FIX: begin
        div_start = 1'b1;
        div_dvd   = {{W{1'b0}}, kadd_r};
      end
      ST_CHECK: begin
        div_start = !(amb_r || mod_r == '0);
        div_dvd   = {{W{1'b0}}, c_r};
      end
      ST_P_MOD: begin
        div_start = 1'b1;
        div_dvd   = prod_r;
      end
      default: ;
    endcase
  end

  assign qs_full = $signed({1'b0, dq_r}) * s_r;
  assign mod_s   = $signed({2'b00, mod_r});
  assign sum     = {1'b0, drem_r} + {1'b0, mod_r} - {1'b0, bm_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ret_r     <= ST_IDLE;
      mod_r     <= W'(26);
      kmul_r    <= W'(1);
      kadd_r    <= '0;
      inv_ok_r  <= 1'b0;
      amb_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      if (cfg_valid) begin
        inv_ok_r <= 1'b0;
        unique case (cfg_index)
          CFG_MODULUS:  mod_r  <= cfg_data;
          CFG_KEY_MULT: kmul_r <= cfg_data;
          CFG_KEY_ADD:  kadd_r <= cfg_data;
          CFG_SPARE:    ;
          default:      ;
        endcase
      end
      if (state_r == ST_INV_FIX) begin
        amb_r <= (or_r != W'(1));
      end
      if (state_r == ST_B_SET) begin
        inv_ok_r <= 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end

    if (in_acc) c_r <= in_tdata[W-1:0];
    if (div_done) begin
      dq_r   <= div_quo[W-1:0];
      drem_r <= div_rem;
    end
    unique case (state_r)
      ST_E_INIT: begin
        or_r <= drem_r;
        r_r  <= mod_r;
        os_r <= (W+2)'(1);
        s_r  <= '0;
      end
      ST_E_MUL: qs_r <= qs_full[W+1:0];
      ST_E_UPD: begin
        or_r <= r_r;
        r_r  <= drem_r;
        os_r <= s_r;
        s_r  <= os_r - qs_r;
      end
      ST_INV_FIX: begin
        if (os_r < 0) begin
          inv_r <= W'(os_r + mod_s);
        end else if (os_r >= mod_s) begin
          inv_r <= W'(os_r - mod_s);
        end else begin
          inv_r <= os_r[W-1:0];
        end
      end
      ST_B_SET: bm_r <= drem_r;
      ST_CHECK: begin
        res_amb_r <= amb_r || mod_r == '0;
        plain_r   <= '0;
      end
      ST_DIFF:    diff_r <= (sum >= {1'b0, mod_r}) ? sum - {1'b0, mod_r} : sum;
      ST_PRODUCT: prod_r <= diff_r[W-1:0] * inv_r;
      ST_FIN:     plain_r <= drem_r;
      default: ;
    endcase
    if (state_r == ST_DONE && out_free) begin
      out_plain_r <= plain_r;
      out_amb_r   <= res_amb_r;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = TW'(out_plain_r);
  assign out_tuser  = out_amb_r;

endmodule

### design/aff_checker.sv
// port-level checks for the affine cipher decrypt core, bound to the top level
// depends on aff_pkg
module aff_checker #(
  parameter int SYMBOL_BITS = 16
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [((SYMBOL_BITS+7)/8)*8-1:0] out_tdata,
  input logic                             out_tuser
);
  import aff_pkg::*;

  // a word in work blocks further input
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in work");

  // ambiguous results carry a zero symbol
  a_amb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("ambiguous result with nonzero symbol");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result shown right after reset");

endmodule

bind affine_cipher_decrypt_core aff_checker #(.SYMBOL_BITS(SYMBOL_BITS)) u_aff_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### sim/tb_affine_cipher_decrypt_core.sv
// testbench for affine_cipher_decrypt_core: drives cipher words and key settings,
// predicts each plaintext word and ambiguous flag, checks them in order
// depends on design/aff_pkg.sv and design/affine_cipher_decrypt_core.sv
module tb_affine_cipher_decrypt_core;
  timeunit 1ns;
  timeprecision 1ps;
  import aff_pkg::*;

  localparam int SB = 16;
  localparam int WATCH_LIMIT = 20000;

  class plain_board;
    bit [15:0] exp_plain[$];
    bit        exp_amb[$];
    bit [15:0] modulus = 26;
    bit [15:0] key_mult = 1;
    bit [15:0] key_add = 0;
    int        errors = 0;

    // extended euclid on the current keys
    function automatic bit inverse_of(output longint inv);
      longint old_r, r, old_s, s, q, t;
      old_r = key_mult % modulus;
      r = modulus;
      old_s = 1;
      s = 0;
      while (r != 0) begin
        q = old_r / r;
        t = old_r - q * r; old_r = r; r = t;
        t = old_s - q * s; old_s = s; s = t;
      end
      if (old_r != 1) return 0;
      inv = old_s % longint'(modulus);
      if (inv < 0) inv += modulus;
      return 1;
    endfunction

    function void note_cipher(bit [15:0] c);
      longint inv, m, diff;
      bit [15:0] plain;
      bit amb;
      plain = 0;
      amb = 1;
      m = modulus;
      if (m != 0 && inverse_of(inv)) begin
        diff = ((c % m) + m - (key_add % m)) % m;
        plain = 16'((diff * inv) % m);
        amb = 0;
      end
      exp_plain.push_back(plain);
      exp_amb.push_back(amb);
    endfunction

    function void check_plain(bit [15:0] plain, bit amb);
      bit [15:0] ep;
      bit ea;
      if (exp_plain.size() == 0) begin
        $display("%0t: unexpected word plain=%0d amb=%0d", $time, plain, amb);
        errors++;
        return;
      end
      ep = exp_plain.pop_front();
      ea = exp_amb.pop_front();
      if (ep !== plain) begin
        $display("%0t: plain_symbol expected %0d actual %0d", $time, ep, plain);
        errors++;
      end
      if (ea !== amb) begin
        $display("%0t: ambiguous expected %0d actual %0d", $time, ea, amb);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [15:0] in_tdata = 0;
  logic out_tvalid, out_tready = 0;
  logic [15:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 0, cfg_ready;
  cfg_idx_t cfg_index = CFG_MODULUS;
  logic [SB-1:0] cfg_data = 0;

  plain_board board = new();
  int send_idle = 0, recv_stall = 0;
  int quiet_cycles = 0;

  affine_cipher_decrypt_core #(.SYMBOL_BITS(SB)) DUT (.*);

  initial forever #6 clk = ~clk;

  // receiver side with random stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_plain(out_tdata, out_tuser);
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("affine_cipher_decrypt_core: mismatch");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, bit [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      CFG_MODULUS:  board.modulus = val;
      CFG_KEY_MULT: board.key_mult = val;
      CFG_KEY_ADD:  board.key_add = val;
      default: ;
    endcase
  endtask

  task automatic send_cipher(bit [15:0] c);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_cipher(c);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.exp_plain.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_keys(bit [15:0] m, bit [15:0] a, bit [15:0] b);
    drain();
    write_reg(CFG_MODULUS, m);
    write_reg(CFG_KEY_MULT, a);
    write_reg(CFG_KEY_ADD, b);
  endtask

  function automatic bit [15:0] rand_sym(bit [15:0] m);
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'hFFFF;
      default: return (m == 0) ? 16'($urandom) : 16'($urandom_range(m - 1));
    endcase
  endfunction

  initial begin
    bit [15:0] m, a;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset keys, extremes, modulus one, zero modulus, zero multiplier, shared factor, large moduli
    send_cipher(0); send_cipher(25); send_cipher(26); send_cipher(16'hFFFF);
    set_keys(26, 7, 3);
    send_cipher(0); send_cipher(2); send_cipher(16'hFFFF); send_cipher(16'h5555);
    set_keys(1, 16'hFFFF, 16'hFFFF);
    send_cipher(16'hFFFF); send_cipher(5);
    set_keys(0, 3, 1);
    send_cipher(7); send_cipher(16'hAAAA);
    set_keys(26, 0, 0);
    send_cipher(9);
    set_keys(26, 13, 5);
    send_cipher(9);
    set_keys(16'hFFFF, 16'hFFFE, 16'hFFFF);
    send_cipher(0); send_cipher(16'hFFFF); send_cipher(16'h1234);
    set_keys(65521, 16'hFFFF, 16'h8000);
    send_cipher(16'hFFFF); send_cipher(1);

    // random phases with different idling
    for (int ph = 0; ph < 20; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 61; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 61; end
        default: begin send_idle = 23; recv_stall = 23; end
      endcase
      case ($urandom_range(3))
        0: m = 16'($urandom_range(2, 40));
        1: m = 16'($urandom_range(1, 65535));
        2: m = 16'hFFFF;
        default: m = 16'($urandom_range(0, 3));
      endcase
      a = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2000));
      set_keys(m, a, 16'($urandom));
      for (int i = 0; i < 51; i++) begin
        send_cipher(rand_sym(m));
        if (i == 25 && ph == 3) drain();
      end
    end
    send_idle = 0;
    recv_stall = 0;
    drain();
    if (board.errors == 0 && board.exp_plain.size() == 0)
      $display("affine_cipher_decrypt_core: match");
    else
      $display("affine_cipher_decrypt_core: mismatch");
    $finish;
  end
endmodule

### affine_cipher_decrypt_core.f
design/aff_pkg.sv
design/aff_div_cell.sv
design/aff_div_chain.sv
design/affine_cipher_decrypt_core.sv
design/aff_checker.sv
sim/tb_affine_cipher_decrypt_core.sv
